// File: hdl/ntls_pkg.sv
// shared types, constants and coefficient tables of the tridiagonal line solver
package ntls_pkg;

  localparam int DATA_W    = 32;
  localparam int LEN_W     = 7;
  localparam int OP_W      = 34;
  localparam int PROD_W    = 66;
  localparam int ROM_DEPTH = 64;
  localparam int ROM_AW    = 6;
  localparam int EXACT_STEPS = 40;

  localparam logic [LEN_W-1:0] LEN_MIN   = 7'd2;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  // (2^32 - 1) / 3, good enough for a floor divide by 3 with up to two corrections
  localparam logic [DATA_W-1:0] DIV3_RECIP  = 32'h5555_5555;
  // 1 + 3 * 2^31: rounding term plus bias that keeps the dividend positive
  localparam logic [OP_W-1:0]   DIV3_OFFSET = 34'h1_8000_0001;
  localparam logic [OP_W-1:0]   DIV3_BIAS   = 34'h0_8000_0000;
  localparam logic [PROD_W:0]   ROUND_HALF  = 67'h4000_0000;

  typedef enum logic {
    MODE_DIV3,
    MODE_SCALE
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD_MUL,
    ST_FWD_FIN,
    ST_EMIT,
    ST_BWD_MUL,
    ST_BWD_FIN
  } state_e;

  typedef logic [ROM_DEPTH-1:0][DATA_W-1:0] rom_t;

  // round(x / y * 2^31) for 0 <= x < y
  function automatic logic [DATA_W-1:0] frac_q31(longint unsigned x, longint unsigned y);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = x;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= y) begin
        r = r - y;
        q = q | 64'd1;
      end
    end
    return DATA_W'((q + 64'd1) >> 1);
  endfunction

  // magnitudes of the forward coefficients, c[k] = -a/b
  function automatic rom_t build_mc_rom();
    rom_t rom;
    longint unsigned a;
    longint unsigned b;
    longint unsigned na;
    a = 2;
    b = 3;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      rom[k] = frac_q31(a, b);
      if (k < EXACT_STEPS) begin
        na = b;
        b  = 3 * b - a;
        a  = na;
      end
    end
    return rom;
  endfunction

  // end-row coefficient 1 / (2 + c[n-2]), entry n-1 for a line of n
  function automatic rom_t build_me_rom();
    rom_t rom;
    longint unsigned a;
    longint unsigned b;
    longint unsigned na;
    a = 2;
    b = 3;
    rom[0] = '0;
    for (int k = 0; k < ROM_DEPTH - 1; k++) begin
      rom[k+1] = frac_q31(b, 2 * b - a);
      if (k < EXACT_STEPS) begin
        na = b;
        b  = 3 * b - a;
        a  = na;
      end
    end
    return rom;
  endfunction

  localparam rom_t MC_ROM = build_mc_rom();
  localparam rom_t ME_ROM = build_me_rom();

endpackage

// File: hdl/neumann_tridiagonal_line_solver_core.sv
// top level of the tridiagonal line solver: sequencer, store, stream and register ports
// Solves one line of the Neumann tridiagonal system (diagonal 3, off-diagonals -1) by the
// Thomas algorithm. Right-hand-side samples (signed Q16.16) arrive one beat at a time on the
// slave stream; line_length (APB offset 0x0, reset 64, values below 2 act as 2, above
// MAX_LINE as MAX_LINE) sets how many make a line, and writing it restarts the line. Each
// sample is accepted, multiplied and committed in turn by the two-stage shared multiplier
// that does every divide-by-3 and coefficient product; the next sample waits for the commit.
// After the last sample the backward sweep emits the solution last index first, one result
// per multiplier loop pass, held while the master stalls; tlast marks the unknown of index 0.
// No new sample is taken during the sweep, but the next line may start while the final
// result waits in the output register. The reduced-rhs store needs no clearing after reset.
module neumann_tridiagonal_line_solver_core import ntls_pkg::*; #(
  parameter int MAX_LINE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // slave stream, tdata: rhs_value[31:0]
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,
  // master stream, tdata: solution_value[31:0]; tlast: last_flag
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE);
  localparam logic REG_LINE_LENGTH = 1'b0;

  state_e                   state_q, state_d;
  logic [LEN_W-1:0]         len_q, n_eff, n_m1;
  logic [IDX_W-1:0]         k_q, j_q;
  logic signed [DATA_W-1:0] prev_q, p_q, rd_q;
  logic [DATA_W-1:0]        out_data_q;
  logic                     out_last_q, out_valid_q;
  logic                     k_last, out_free, cfg_we;

  // sequencer controls
  mode_e                    mul_mode;
  logic signed [OP_W-1:0]   mul_op;
  logic [DATA_W-1:0]        mul_coef;
  logic signed [DATA_W-1:0] mul_addend, mul_res;
  logic                     commit_fwd, commit_bwd, out_load, rd_en;

  logic signed [DATA_W-1:0] store_mem [MAX_LINE];

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_LINE_LENGTH);
  assign prdata = (paddr[2] == REG_LINE_LENGTH) ? {{(32-LEN_W){1'b0}}, len_q} : '0;

  // clamp the programmed length into the supported range
  always_comb begin
    priority if (len_q < LEN_MIN) begin
      n_eff = LEN_MIN;
    end else if (len_q > MAX_LEN) begin
      n_eff = MAX_LEN;
    end else begin
      n_eff = len_q;
    end
  end
  assign n_m1   = n_eff - 1'b1;
  assign k_last = (LEN_W'(k_q) == n_m1);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // next state and unit operand selection
  always_comb begin
    state_d    = state_q;
    mul_mode   = MODE_SCALE;
    mul_op     = {{(OP_W-DATA_W){p_q[DATA_W-1]}}, p_q};
    mul_coef   = MC_ROM[ROM_AW'(j_q - 1'b1)];
    mul_addend = '0;
    commit_fwd = 1'b0;
    commit_bwd = 1'b0;
    out_load   = 1'b0;
    rd_en      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // sample 0 divided by 3; others plus prev scaled by -c[k], last by end-row coef
        if (k_q == '0) begin
          mul_mode = MODE_DIV3;
          mul_op   = {{(OP_W-DATA_W){s_axis_tdata[DATA_W-1]}}, s_axis_tdata};
        end else begin
          mul_op = {{(OP_W-DATA_W){s_axis_tdata[DATA_W-1]}}, s_axis_tdata}
                 + {{(OP_W-DATA_W){prev_q[DATA_W-1]}}, prev_q};
        end
        mul_coef = k_last ? ME_ROM[ROM_AW'(n_m1)] : MC_ROM[ROM_AW'(k_q)];
        if (s_axis_tvalid) begin
          state_d = ST_FWD_MUL;
        end
      end
      ST_FWD_MUL: state_d = ST_FWD_FIN;
      ST_FWD_FIN: begin
        commit_fwd = 1'b1;
        state_d    = k_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // pass p to output when free, then next back-substitution step or idle at index 0
        if (out_free) begin
          out_load = 1'b1;
          if (j_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            state_d = ST_BWD_MUL;
          end
        end
      end
      ST_BWD_MUL: state_d = ST_BWD_FIN;
      ST_BWD_FIN: begin
        mul_addend = rd_q;
        commit_bwd = 1'b1;
        state_d    = ST_EMIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ntls_mult u_mult (
    .clk_i    (clk_i),
    .mode_i   (mul_mode),
    .op_i     (mul_op),
    .coef_i   (mul_coef),
    .addend_i (mul_addend),
    .res_o    (mul_res)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_RESET;
      k_q         <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        len_q <= pwdata[LEN_W-1:0];
        k_q   <= '0;
      end else if (commit_fwd) begin
        k_q <= k_last ? '0 : k_q + 1'b1;
      end
      if (commit_fwd) begin
        prev_q <= mul_res;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (commit_fwd && k_last) begin
      p_q <= mul_res;
      j_q <= IDX_W'(n_m1);
    end else if (commit_bwd) begin
      p_q <= mul_res;
    end else if (out_load && (j_q != '0)) begin
      j_q <= j_q - 1'b1;
    end
    if (out_load) begin
      out_data_q <= p_q;
      out_last_q <= (j_q == '0);
    end
  end

  // reduced rhs store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (commit_fwd) begin
      store_mem[k_q] <= mul_res;
    end
    if (rd_en) begin
      rd_q <= store_mem[j_q - 1'b1];
    end
  end

endmodule

// File: hdl/ntls_mult.sv
// shared two-stage multiply unit with rounding, divide-by-3 and saturation
module ntls_mult import ntls_pkg::*; (
  input  logic                     clk_i,
  input  mode_e                    mode_i,
  input  logic signed [OP_W-1:0]   op_i,
  input  logic [DATA_W-1:0]        coef_i,
  input  logic signed [DATA_W-1:0] addend_i,
  output logic signed [DATA_W-1:0] res_o
);

  mode_e              mode1_q, mode2_q;
  logic [OP_W-1:0]    mag_d, mag_q;
  logic               neg_d, neg1_q, neg2_q;
  logic [DATA_W-1:0]  coef_d, coef_q;
  logic [PROD_W-1:0]  prod_q;
  logic [3:0]         lo_q;

  // operand conditioning
  always_comb begin
    unique case (mode_i)
      MODE_DIV3: begin
        mag_d  = op_i + DIV3_OFFSET;
        neg_d  = 1'b0;
        coef_d = DIV3_RECIP;
      end
      MODE_SCALE: begin
        neg_d  = op_i[OP_W-1];
        mag_d  = neg_d ? -op_i : op_i;
        coef_d = coef_i;
      end
      default: begin
        mag_d  = '0;
        neg_d  = 1'b0;
        coef_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mode1_q <= mode_i;
    mag_q   <= mag_d;
    neg1_q  <= neg_d;
    coef_q  <= coef_d;
    mode2_q <= mode1_q;
    neg2_q  <= neg1_q;
    lo_q    <= mag_q[3:0];
    prod_q  <= PROD_W'(mag_q) * PROD_W'(coef_q);
  end

  logic [OP_W-1:0]          q0, qd;
  logic [3:0]               rem;
  logic [PROD_W:0]          rsum;
  logic [35:0]              rq;
  logic signed [36:0]       sq, tot;

  always_comb begin
    // floor divide by 3, remainder kept mod 16 since it stays below 9
    q0  = prod_q[PROD_W-1:32];
    rem = lo_q - q0[3:0] - {q0[2:0], 1'b0};
    qd  = q0 + OP_W'(rem >= 4'd3) + OP_W'(rem >= 4'd6);
    // Q0.31 scale, halves away from zero
    rsum = {1'b0, prod_q} + ROUND_HALF;
    rq   = rsum[PROD_W:31];
    sq   = neg2_q ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    tot  = sq + $signed({{5{addend_i[DATA_W-1]}}, addend_i});
    unique case (mode2_q)
      MODE_DIV3: res_o = DATA_W'(qd - DIV3_BIAS);
      MODE_SCALE: begin
        if (!tot[36] && (|tot[35:31])) begin
          res_o = 32'sh7fff_ffff;
        end else if (tot[36] && !(&tot[35:31])) begin
          res_o = 32'sh8000_0000;
        end else begin
          res_o = tot[DATA_W-1:0];
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule
